>>> hdl/mbr_partition_entry_encoder_top_macros.svh
// Assertion helpers used by the encoder back end.
`ifndef MBR_PARTITION_ENTRY_ENCODER_TOP_MACROS_SVH
`define MBR_PARTITION_ENTRY_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mpe_pkg.sv
package mpe_pkg;

  // Input word
  typedef struct packed {
    logic [31:0] start_sector;
    logic [31:0] sector_length;
    logic        is_extended;
    logic [31:0] base_sector;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0]  start_head;
    logic [7:0]  start_cyl_sector;
    logic [7:0]  start_cyl_low;
    logic [7:0]  part_type;
    logic [7:0]  end_head;
    logic [7:0]  end_cyl_sector;
    logic [7:0]  end_cyl_low;
    logic [31:0] relative_start;
    logic [31:0] length_out;
    logic        chs_clamped;
  } out_word_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] len;
    logic [31:0] rel;
    logic        ext;
  } job_t;

  // Geometry seen by the back end
  typedef struct packed {
    logic [5:0]  spt;
    logic [8:0]  hc;
    logic [10:0] lim;
    logic        lba;
  } geom_t;

  // Register indexes
  typedef enum logic [7:0] {
    REG_SPT   = 8'd0,
    REG_HEADS = 8'd1,
    REG_CYLS  = 8'd2,
    REG_LBA   = 8'd3
  } reg_idx_t;

  localparam logic [5:0]  SPT_RESET  = 6'd32;
  localparam logic [8:0]  HC_RESET   = 9'd16;
  localparam logic [10:0] LIM_RESET  = 11'd1024;

  localparam logic [31:0] LEN_BIG    = 32'h0080_0000;
  localparam logic [31:0] LEN_MID    = 32'h0001_0000;

  localparam logic [7:0] TYPE_FAT12     = 8'h01;
  localparam logic [7:0] TYPE_EXT_CHS   = 8'h05;
  localparam logic [7:0] TYPE_FAT16     = 8'h06;
  localparam logic [7:0] TYPE_FAT32     = 8'h0B;
  localparam logic [7:0] TYPE_FAT32_LBA = 8'h0C;
  localparam logic [7:0] TYPE_FAT16_LBA = 8'h0E;
  localparam logic [7:0] TYPE_EXT_LBA   = 8'h0F;

endpackage

>>> hdl/mpe_front.sv
module mpe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mpe_pkg::in_word_t in_word,
  output logic             q_push,
  input  logic             q_full,
  output mpe_pkg::job_t    q_job
);

  logic          held;
  mpe_pkg::job_t job;

  // Stall only while a held word cannot move to the queue
  assign in_stall = held && q_full;
  assign q_push   = held && !q_full;
  assign q_job    = job;

  // Capture word, form last sector and relative start
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
    if (!in_stall) begin
      job.first <= in_word.start_sector;
      job.last  <= in_word.start_sector + in_word.sector_length - 32'd1;
      job.len   <= in_word.sector_length;
      job.rel   <= in_word.start_sector - in_word.base_sector;
      job.ext   <= in_word.is_extended;
    end
  end

endmodule

>>> hdl/mpe_fifo.sv
module mpe_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mpe_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output mpe_pkg::job_t head_job
);

  mpe_pkg::job_t mem [0:3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full     = count[2];
  assign empty    = (count == 3'd0);
  assign head_job = mem[rd_ptr];

  // Four-entry job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      if (push && !pop)      count <= count + 3'd1;
      else if (pop && !push) count <= count - 3'd1;
    end
    if (push) mem[wr_ptr] <= push_job;
  end

endmodule

>>> hdl/mpe_back.sv
`include "mbr_partition_entry_encoder_top_macros.svh"

module mpe_back (
  input  logic              clk,
  input  logic              rst,
  input  mpe_pkg::geom_t    geom,
  input  logic              q_empty,
  input  mpe_pkg::job_t     q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mpe_pkg::out_word_t out_word
);

  // Divider lane: shifting dividend/quotient word and partial remainder
  typedef struct packed {
    logic [31:0] w;
    logic [9:0]  rem;
  } lane_t;

  typedef struct packed {
    mpe_pkg::job_t job;
    lane_t         s;
    lane_t         e;
    logic [5:0]    sec_s;
    logic [5:0]    sec_e;
  } stage_t;

  stage_t st  [0:64];
  logic   vld [0:64];
  logic   adv;

  logic [5:0]  spt_eff;
  logic [8:0]  hc_eff;
  logic [10:0] lim_eff;

  assign spt_eff = (geom.spt == 6'd0) ? 6'd1 : geom.spt;
  assign hc_eff  = (geom.hc == 9'd0) ? 9'd1 : geom.hc;
  assign lim_eff = (geom.lim == 11'd0) ? 11'd1 : geom.lim;

  // Whole pipe moves when the output register is free
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // One restoring-division step: one quotient bit
  function automatic lane_t div_step(lane_t x, logic [9:0] d);
    logic [10:0] r;
    logic        ge;
    lane_t       y;
    r     = {x.rem, x.w[31]};
    ge    = (r >= {1'b0, d});
    y.w   = {x.w[30:0], ge};
    y.rem = ge ? (r[9:0] - d) : r[9:0];
    return y;
  endfunction

  // Stages 0..31 divide by sectors per track, 32..63 by head count
  function automatic stage_t stage_step(stage_t x, logic [9:0] d, logic mid);
    stage_t y;
    y = x;
    if (mid) begin
      y.sec_s = x.s.rem[5:0];
      y.sec_e = x.e.rem[5:0];
      y.s.rem = 10'd0;
      y.e.rem = 10'd0;
    end
    y.s = div_step(y.s, d);
    y.e = div_step(y.e, d);
    return y;
  endfunction

  // Cylinder clamp and CHS byte packing
  function automatic logic [24:0] chs_pack(lane_t x, logic [5:0] sec, logic [10:0] lim);
    logic        c;
    logic [31:0] cyl;
    c   = (x.w >= {21'd0, lim});
    cyl = c ? {21'd0, lim - 11'd1} : x.w;
    return {c, x.rem[7:0], cyl[9:8], sec, cyl[7:0]};
  endfunction

  logic [24:0] pk_s;
  logic [24:0] pk_e;
  logic        any_clamp;
  logic        chs_ok;
  logic [7:0]  ptype;

  // CHS packing, clamp flag and partition type selection
  always_comb begin
    pk_s      = chs_pack(st[64].s, st[64].sec_s, lim_eff);
    pk_e      = chs_pack(st[64].e, st[64].sec_e, lim_eff);
    any_clamp = pk_s[24] || pk_e[24];
    chs_ok    = !any_clamp && !geom.lba;
    if (st[64].job.ext) begin
      ptype = chs_ok ? mpe_pkg::TYPE_EXT_CHS : mpe_pkg::TYPE_EXT_LBA;
    end else if (chs_ok) begin
      if (st[64].job.len >= mpe_pkg::LEN_BIG)      ptype = mpe_pkg::TYPE_FAT32;
      else if (st[64].job.len >= mpe_pkg::LEN_MID) ptype = mpe_pkg::TYPE_FAT16;
      else                                         ptype = mpe_pkg::TYPE_FAT12;
    end else begin
      ptype = (st[64].job.len >= mpe_pkg::LEN_BIG) ?
              mpe_pkg::TYPE_FAT32_LBA : mpe_pkg::TYPE_FAT16_LBA;
    end
  end

  // Divider pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= 64; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= !q_empty;
      for (int k = 0; k < 64; k++) vld[k+1] <= vld[k];
      out_valid <= vld[64];
    end
    if (adv) begin
      st[0].job   <= q_job;
      st[0].s.w   <= q_job.first;
      st[0].s.rem <= 10'd0;
      st[0].e.w   <= q_job.last;
      st[0].e.rem <= 10'd0;
      st[0].sec_s <= 6'd0;
      st[0].sec_e <= 6'd0;
      for (int k = 0; k < 64; k++) begin
        st[k+1] <= stage_step(st[k], (k >= 32) ? {1'b0, hc_eff} : {4'd0, spt_eff},
                              k == 32);
      end
      out_word.start_head       <= pk_s[23:16];
      out_word.start_cyl_sector <= pk_s[15:8];
      out_word.start_cyl_low    <= pk_s[7:0];
      out_word.part_type        <= ptype;
      out_word.end_head         <= pk_e[23:16];
      out_word.end_cyl_sector   <= pk_e[15:8];
      out_word.end_cyl_low      <= pk_e[7:0];
      out_word.relative_start   <= st[64].job.rel;
      out_word.length_out       <= st[64].job.len;
      out_word.chs_clamped      <= any_clamp;
    end
  end

  // Output carries one of the LBA-mapped type codes
  logic out_lba_type;
  assign out_lba_type = (out_word.part_type == mpe_pkg::TYPE_EXT_LBA) ||
                        (out_word.part_type == mpe_pkg::TYPE_FAT32_LBA) ||
                        (out_word.part_type == mpe_pkg::TYPE_FAT16_LBA);

  `MPE_ASSERT_NOW(a_clamp_type, out_valid && out_word.chs_clamped, out_lba_type, "clamped CHS type")
  `MPE_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
  `MPE_ASSERT_NEXT(a_pipe_move, adv && vld[64], out_valid, "finished entry not presented")

endmodule

>>> hdl/mbr_partition_entry_encoder_top.sv
// MBR partition entry encoder.
// Throughput: one word per cycle while out_stall is low; two 32-stage bit-per-cycle
// divider chains set the latency.
// A four-entry queue separates the input stage from the divider pipeline.
// Reset (rst, synchronous): pipe emptied, geometry back to 32 sectors, 16 heads,
// 1024 cylinders, CHS type codes.
module mbr_partition_entry_encoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mpe_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mpe_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  mpe_pkg::geom_t geom;
  mpe_pkg::job_t  f_job;
  mpe_pkg::job_t  h_job;
  logic           f_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // Geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.spt <= mpe_pkg::SPT_RESET;
      geom.hc  <= mpe_pkg::HC_RESET;
      geom.lim <= mpe_pkg::LIM_RESET;
      geom.lba <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpe_pkg::REG_SPT:   geom.spt <= cfg_data[5:0];
        mpe_pkg::REG_HEADS: geom.hc  <= cfg_data[8:0];
        mpe_pkg::REG_CYLS:  geom.lim <= cfg_data[10:0];
        mpe_pkg::REG_LBA:   geom.lba <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_push   (f_push),
    .q_full   (q_full),
    .q_job    (f_job)
  );

  mpe_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .push_job (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (h_job)
  );

  mpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_empty   (q_empty),
    .q_job     (h_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> bench/mbr_partition_entry_encoder_top_test.sv
module mbr_partition_entry_encoder_top_test;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  mpe_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  mpe_pkg::out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  mbr_partition_entry_encoder_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Geometry copy used by the predictor
  logic [5:0]  geo_spt;
  logic [8:0]  geo_heads;
  logic [10:0] geo_cyls;
  logic        geo_lba;

  mpe_pkg::out_word_t entry_q[$];
  int  mismatches = 0;
  bit  quiet_tail = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;

  // Split one sector number into CHS bytes; returns 1 on cylinder clamp
  function automatic bit split_chs(input logic [31:0] s, output logic [7:0] hd,
                                   output logic [7:0] cs, output logic [7:0] cl);
    logic [31:0] spt, hc, lim, track, cyl, sec;
    bit clamp;
    spt = (geo_spt == 0) ? 32'd1 : 32'(geo_spt);
    hc = (geo_heads == 0) ? 32'd1 : 32'(geo_heads);
    lim = (geo_cyls == 0) ? 32'd1 : 32'(geo_cyls);
    track = s / spt;
    cyl = track / hc;
    sec = (s % spt) & 32'h3F;
    clamp = 0;
    if (cyl >= lim) begin
      cyl = lim - 1;
      clamp = 1;
    end
    hd = 8'(track % hc);
    cs = 8'(((cyl & 32'h300) >> 2) | sec);
    cl = 8'(cyl);
    return clamp;
  endfunction

  function automatic mpe_pkg::out_word_t encode_entry(input mpe_pkg::in_word_t w);
    mpe_pkg::out_word_t e;
    bit c1, c2, chs_ok;
    logic [31:0] last;
    last = w.start_sector + w.sector_length - 32'd1;
    c1 = split_chs(w.start_sector, e.start_head, e.start_cyl_sector, e.start_cyl_low);
    c2 = split_chs(last, e.end_head, e.end_cyl_sector, e.end_cyl_low);
    chs_ok = !c1 && !c2 && !geo_lba;
    if (w.is_extended) begin
      e.part_type = chs_ok ? mpe_pkg::TYPE_EXT_CHS : mpe_pkg::TYPE_EXT_LBA;
    end else if (chs_ok) begin
      if (w.sector_length >= mpe_pkg::LEN_BIG) e.part_type = mpe_pkg::TYPE_FAT32;
      else if (w.sector_length >= mpe_pkg::LEN_MID) e.part_type = mpe_pkg::TYPE_FAT16;
      else e.part_type = mpe_pkg::TYPE_FAT12;
    end else begin
      e.part_type = (w.sector_length >= mpe_pkg::LEN_BIG) ?
                    mpe_pkg::TYPE_FAT32_LBA : mpe_pkg::TYPE_FAT16_LBA;
    end
    e.relative_start = w.start_sector - w.base_sector;
    e.length_out = w.sector_length;
    e.chs_clamped = c1 || c2;
    return e;
  endfunction

  // Receiver stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    mpe_pkg::out_word_t exp_e;
    if (!rst && out_valid && !out_stall) begin
      if (entry_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word);
      end else begin
        exp_e = entry_q.pop_front();
        if (out_word !== exp_e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_e, out_word);
        end
      end
    end
  end

  // Watchdog on accept activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("mbr_partition_entry_encoder_top_test: errors");
      $finish;
    end
  end

  task automatic send_entry(input mpe_pkg::in_word_t w);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entry_q.push_back(encode_entry(w));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (entry_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Valid stays up across back-to-back writes; the caller drops it
  task automatic write_reg(input mpe_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mpe_pkg::REG_SPT: geo_spt = val[5:0];
      mpe_pkg::REG_HEADS: geo_heads = val[8:0];
      mpe_pkg::REG_CYLS: geo_cyls = val[10:0];
      mpe_pkg::REG_LBA: geo_lba = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int spt, input int hc, input int cyl, input int lba);
    drain();
    write_reg(mpe_pkg::REG_SPT, 16'(spt));
    write_reg(mpe_pkg::REG_HEADS, 16'(hc));
    write_reg(mpe_pkg::REG_CYLS, 16'(cyl));
    write_reg(mpe_pkg::REG_LBA, 16'(lba));
    cfg_valid <= 1'b0;
  endtask

  function automatic mpe_pkg::in_word_t rand_entry(input int span);
    mpe_pkg::in_word_t w;
    int sel;
    sel = $urandom_range(0, 3);
    w.start_sector = (sel == 0) ? $urandom() : $urandom_range(0, span);
    case ($urandom_range(0, 3))
      0: w.sector_length = $urandom_range(0, 32'hFFFF);
      1: w.sector_length = $urandom_range(32'h10000, 32'h7FFFFF);
      2: w.sector_length = $urandom_range(0, span);
      default: w.sector_length = $urandom();
    endcase
    w.is_extended = 1'($urandom_range(0, 1));
    w.base_sector = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, w.start_sector);
    return w;
  endfunction

  // Field extremes, every type code except the CHS FAT32 code, zero length and wrap
  task automatic test_directed;
    logic [31:0] lens[6] = '{32'd0, 32'd1, 32'hFFFF, 32'h10000, 32'h800000, 32'hFFFFFFFF};
    foreach (lens[i]) begin
      send_entry('{32'd0, lens[i], 1'b0, 32'd0});
      send_entry('{32'd100, lens[i], 1'b1, 32'd50});
    end
    send_entry('{32'hFFFFFFFF, 32'd2, 1'b0, 32'hFFFFFFFF});
    send_entry('{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0});
    send_entry('{32'd0, 32'd0, 1'b1, 32'hFFFFFFFF});
    send_entry('{32'd524287, 32'd1, 1'b0, 32'd1});
    send_entry('{32'd524288, 32'h10000, 1'b0, 32'd0});
    send_entry('{32'hAAAAAAAA, 32'h55555555, 1'b0, 32'h55555555});
    send_entry('{32'h55555555, 32'hAAAAAAAA, 1'b1, 32'hAAAAAAAA});
  endtask

  task automatic test_random(input int count, input int span);
    repeat (count) send_entry(rand_entry(span));
  endtask

  initial begin
    geo_spt = mpe_pkg::SPT_RESET;
    geo_heads = mpe_pkg::HC_RESET;
    geo_cyls = mpe_pkg::LIM_RESET;
    geo_lba = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(120, 600000);
    set_geometry(63, 255, 1024, 0);
    test_random(100, 20000000);
    set_geometry(1, 1, 1, 1);
    test_directed();
    test_random(60, 4);
    set_geometry(0, 0, 0, 0);
    test_random(60, 8);
    set_geometry(63, 511, 2047, 0);
    test_random(80, 70000000);
    set_geometry(17, 256, 2000, 1);
    test_random(80, 40000000);
    set_geometry(9, 300, 37, 0);
    quiet_tail = 1;
    test_random(100, 200000);
    drain();
    if (mismatches == 0 && entry_q.size() == 0) begin
      $display("mbr_partition_entry_encoder_top_test: clean");
    end else begin
      $display("mbr_partition_entry_encoder_top_test: errors");
    end
    $finish;
  end
endmodule
